@@ design/dht_pkg.sv @@
`timescale 1ns / 1ps
package dht_pkg;

    localparam int FRAME_BITS      = 40;
    localparam int START_GAP_TICKS = 30;

    localparam int TICK_W   = 10;
    localparam int BIT_IDX_W = 6;
    localparam int READ_W   = 10;
    localparam int TEMP_W   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] REG_RESP_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESP_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL_LOW  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_RD = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_C  = 3'd7;

    localparam logic [TICK_W-1:0] RST_RESP_LOW  = 10'd80;
    localparam logic [TICK_W-1:0] RST_RESP_HIGH = 10'd80;
    localparam logic [TICK_W-1:0] RST_BIT_LOW   = 10'd50;
    localparam logic [TICK_W-1:0] RST_ZERO_HIGH = 10'd26;
    localparam logic [TICK_W-1:0] RST_ONE_HIGH  = 10'd70;
    localparam logic [TICK_W-1:0] RST_TAIL_LOW  = 10'd50;
    localparam logic [READ_W-1:0] RST_ANCHOR_RD = 10'd248;
    localparam logic signed [TEMP_W-1:0] RST_ANCHOR_C = 8'sd22;

    typedef struct packed {
        logic [TICK_W-1:0]        response_low_ticks;
        logic [TICK_W-1:0]        response_high_ticks;
        logic [TICK_W-1:0]        bit_low_ticks;
        logic [TICK_W-1:0]        zero_high_ticks;
        logic [TICK_W-1:0]        one_high_ticks;
        logic [TICK_W-1:0]        tail_low_ticks;
        logic [READ_W-1:0]        anchor_reading;
        logic signed [TEMP_W-1:0] anchor_celsius;
    } cfg_t;

endpackage

@@ design/dht_in_if.sv @@
`timescale 1ns / 1ps
interface dht_in_if;
    logic                            valid;
    logic                            ready;
    logic                            line_level;
    logic [dht_pkg::READ_W-1:0]      raw_reading;

    modport source (output valid, output line_level, output raw_reading, input ready);
    modport sink   (input valid, input line_level, input raw_reading, output ready);
endinterface

@@ design/dht_out_if.sv @@
`timescale 1ns / 1ps
interface dht_out_if;
    logic                            valid;
    logic                            ready;
    logic                            drive_enable;
    logic                            drive_level;
    logic                            frame_done;
    logic [dht_pkg::TEMP_W-1:0]      sent_temperature;

    modport source (output valid, output drive_enable, output drive_level,
                    output frame_done, output sent_temperature, input ready);
    modport sink   (input valid, input drive_enable, input drive_level,
                    input frame_done, input sent_temperature, output ready);
endinterface

@@ design/dht_cfg_regs.sv @@
`timescale 1ns / 1ps
module dht_cfg_regs
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [dht_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dht_pkg::CFG_DATA_W-1:0]    cfg_data,
    output dht_pkg::cfg_t                     cfg
);

    dht_pkg::cfg_t cfg_reg;
    dht_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                dht_pkg::REG_RESP_LOW:  cfg_next.response_low_ticks  = cfg_data;
                dht_pkg::REG_RESP_HIGH: cfg_next.response_high_ticks = cfg_data;
                dht_pkg::REG_BIT_LOW:   cfg_next.bit_low_ticks       = cfg_data;
                dht_pkg::REG_ZERO_HIGH: cfg_next.zero_high_ticks     = cfg_data;
                dht_pkg::REG_ONE_HIGH:  cfg_next.one_high_ticks      = cfg_data;
                dht_pkg::REG_TAIL_LOW:  cfg_next.tail_low_ticks      = cfg_data;
                dht_pkg::REG_ANCHOR_RD: cfg_next.anchor_reading      = cfg_data;
                dht_pkg::REG_ANCHOR_C:  cfg_next.anchor_celsius      =
                                            cfg_data[dht_pkg::TEMP_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.response_low_ticks  <= dht_pkg::RST_RESP_LOW;
            cfg_reg.response_high_ticks <= dht_pkg::RST_RESP_HIGH;
            cfg_reg.bit_low_ticks       <= dht_pkg::RST_BIT_LOW;
            cfg_reg.zero_high_ticks     <= dht_pkg::RST_ZERO_HIGH;
            cfg_reg.one_high_ticks      <= dht_pkg::RST_ONE_HIGH;
            cfg_reg.tail_low_ticks      <= dht_pkg::RST_TAIL_LOW;
            cfg_reg.anchor_reading      <= dht_pkg::RST_ANCHOR_RD;
            cfg_reg.anchor_celsius      <= dht_pkg::RST_ANCHOR_C;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ design/dht_core.sv @@
`timescale 1ns / 1ps
module dht_core
(
    input  logic          clk,
    input  logic          rst_n,
    input  dht_pkg::cfg_t cfg,
    dht_in_if.sink        in_ch,
    dht_out_if.source     out_ch
);

    localparam logic [3:0] PH_IDLE         = 4'd0;
    localparam logic [3:0] PH_WAIT_RELEASE = 4'd1;
    localparam logic [3:0] PH_GAP          = 4'd2;
    localparam logic [3:0] PH_RESP_LOW     = 4'd3;
    localparam logic [3:0] PH_RESP_HIGH    = 4'd4;
    localparam logic [3:0] PH_BIT_LOW      = 4'd5;
    localparam logic [3:0] PH_BIT_HIGH     = 4'd6;
    localparam logic [3:0] PH_TAIL         = 4'd7;
    localparam logic [3:0] PH_DONE         = 4'd8;

    localparam logic [dht_pkg::TICK_W-1:0] GAP_TICKS =
        dht_pkg::TICK_W'(dht_pkg::START_GAP_TICKS);
    localparam logic [dht_pkg::BIT_IDX_W-1:0] LAST_POS =
        dht_pkg::BIT_IDX_W'(dht_pkg::FRAME_BITS - 1);
    localparam logic [dht_pkg::BIT_IDX_W-1:0] NUM_BITS =
        dht_pkg::BIT_IDX_W'(dht_pkg::FRAME_BITS);

    logic [3:0]                            phase_reg, phase_next;
    logic [dht_pkg::TICK_W-1:0]            tick_count_reg, tick_count_next;
    logic [dht_pkg::BIT_IDX_W-1:0]         bit_index_reg, bit_index_next;
    logic [dht_pkg::FRAME_BITS-1:0]        frame_bits_reg, frame_bits_next;
    logic [dht_pkg::TEMP_W-1:0]            temp_byte_reg, temp_byte_next;

    logic                                  out_valid_reg;
    logic                                  drive_enable_reg, drive_enable_next;
    logic                                  drive_level_reg, drive_level_next;
    logic                                  frame_done_reg, frame_done_next;

    logic                                  accept;
    logic [dht_pkg::TICK_W-1:0]            tick_inc;
    logic [dht_pkg::TICK_W-1:0]            duration;
    logic                                  elapsed;
    logic [dht_pkg::BIT_IDX_W-1:0]         bit_pos;
    logic [dht_pkg::BIT_IDX_W-1:0]         bit_inc;
    logic                                  cur_bit;
    logic [dht_pkg::TEMP_W-1:0]            temp_calc;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    assign tick_inc  = tick_count_reg + 1'b1;
    assign bit_pos   = LAST_POS - bit_index_reg;
    assign bit_inc   = bit_index_reg + 1'b1;
    assign cur_bit   = (bit_index_reg < NUM_BITS) ? frame_bits_reg[bit_pos] : 1'b0;
    assign temp_calc = cfg.anchor_celsius + in_ch.raw_reading[dht_pkg::TEMP_W-1:0]
                     - cfg.anchor_reading[dht_pkg::TEMP_W-1:0];

    always_comb
    begin
        unique case (phase_reg)
            PH_GAP:       duration = GAP_TICKS;
            PH_RESP_LOW:  duration = cfg.response_low_ticks;
            PH_RESP_HIGH: duration = cfg.response_high_ticks;
            PH_BIT_LOW:   duration = cfg.bit_low_ticks;
            PH_BIT_HIGH:  duration = cur_bit ? cfg.one_high_ticks : cfg.zero_high_ticks;
            PH_TAIL:      duration = cfg.tail_low_ticks;
            default:      duration = GAP_TICKS;
        endcase
    end

    assign elapsed = (tick_inc >= duration);

    always_comb
    begin
        phase_next        = phase_reg;
        tick_count_next   = tick_count_reg;
        bit_index_next    = bit_index_reg;
        frame_bits_next   = frame_bits_reg;
        temp_byte_next    = temp_byte_reg;
        drive_enable_next = 1'b0;
        drive_level_next  = 1'b0;
        frame_done_next   = 1'b0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (!in_ch.line_level)
                    phase_next = PH_WAIT_RELEASE;
            end
            PH_WAIT_RELEASE:
            begin
                if (in_ch.line_level)
                begin
                    phase_next      = PH_GAP;
                    tick_count_next = '0;
                end
            end
            PH_GAP:
            begin
                tick_count_next = elapsed ? '0 : tick_inc;
                if (elapsed)
                begin
                    temp_byte_next  = temp_calc;
                    frame_bits_next = {16'd0, temp_calc, 8'd0, temp_calc};
                    bit_index_next  = '0;
                    phase_next      = PH_RESP_LOW;
                end
            end
            PH_RESP_LOW, PH_RESP_HIGH, PH_BIT_LOW, PH_TAIL:
            begin
                drive_enable_next = 1'b1;
                drive_level_next  = (phase_reg == PH_RESP_HIGH);
                tick_count_next   = elapsed ? '0 : tick_inc;
                if (elapsed)
                begin
                    unique case (phase_reg)
                        PH_RESP_LOW:  phase_next = PH_RESP_HIGH;
                        PH_RESP_HIGH: phase_next = PH_BIT_LOW;
                        PH_BIT_LOW:   phase_next = PH_BIT_HIGH;
                        default:      phase_next = PH_DONE;
                    endcase
                end
            end
            PH_BIT_HIGH:
            begin
                drive_enable_next = 1'b1;
                drive_level_next  = 1'b1;
                tick_count_next   = elapsed ? '0 : tick_inc;
                if (elapsed)
                begin
                    bit_index_next = bit_inc;
                    phase_next     = (bit_inc >= NUM_BITS) ? PH_TAIL : PH_BIT_LOW;
                end
            end
            PH_DONE:
            begin
                frame_done_next = 1'b1;
                phase_next      = PH_IDLE;
                tick_count_next = '0;
            end
            default:
            begin
                phase_next      = PH_IDLE;
                tick_count_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            tick_count_reg <= '0;
            bit_index_reg  <= '0;
            frame_bits_reg <= '0;
            temp_byte_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg      <= phase_next;
                tick_count_reg <= tick_count_next;
                bit_index_reg  <= bit_index_next;
                frame_bits_reg <= frame_bits_next;
                temp_byte_reg  <= temp_byte_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            drive_enable_reg <= drive_enable_next;
            drive_level_reg  <= drive_level_next;
            frame_done_reg   <= frame_done_next;
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.drive_enable     = drive_enable_reg;
    assign out_ch.drive_level      = drive_level_reg;
    assign out_ch.frame_done       = frame_done_reg;
    assign out_ch.sent_temperature = temp_byte_reg;

    a_level_needs_drive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && drive_level_reg |-> drive_enable_reg)
        else $error("driven high level without drive enable");

    a_done_releases: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && frame_done_reg |-> !drive_enable_reg)
        else $error("frame done while still driving");

    a_bit_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_index_reg <= NUM_BITS)
        else $error("bit index beyond frame");

    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == PH_DONE |=> phase_reg == PH_IDLE)
        else $error("release tick did not return to idle");

    a_high_bit_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_BIT_HIGH |-> bit_index_reg < NUM_BITS)
        else $error("data bit phase past last bit");

endmodule

@@ design/dht11_single_wire_responder.sv @@
`timescale 1ns / 1ps
// Channel   Dir   Payload                                            Handshake
// in_ch     in    line_level, raw_reading                            valid/ready
// out_ch    out   drive_enable, drive_level, frame_done,             valid/ready
//                 sent_temperature
// cfg       in    cfg_index, cfg_data                                cfg_we
//
// One tick item in, one result item out; one item per cycle sustained while
// out_ch.ready is high. The phase sequencer and the result register update on
// the accepting edge.
// Reset clears the sequencer, the output valid and loads the register defaults.
// A stalled result holds in the output register; in_ch.ready is low only while
// it waits and out_ch.ready is low.
module dht11_single_wire_responder
(
    input  logic                            clk,
    input  logic                            rst_n,
    dht_in_if.sink                          in_ch,
    dht_out_if.source                       out_ch,
    input  logic                            cfg_we,
    input  logic [dht_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dht_pkg::CFG_DATA_W-1:0]  cfg_data
);

    dht_pkg::cfg_t cfg;

    dht_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dht_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

endmodule
